[rtl/core/radio_packet_framer_sum8_top_macros.svh]
// Assertion helpers used by the framer back end.
`ifndef RADIO_PACKET_FRAMER_SUM8_TOP_MACROS_SVH
`define RADIO_PACKET_FRAMER_SUM8_TOP_MACROS_SVH

// Checks that an expression holds at every rising clock edge outside reset.
`define RPFS_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error("framer assertion failed");

// Checks that a condition implies a consequence in the same cycle.
`define RPFS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("framer assertion failed");

`endif

[rtl/core/rpfs_pkg.sv]
package rpfs_pkg;

    // Kind of work that the front end hands to the back end.
    typedef enum logic [1:0] {
        JOB_HEADER,
        JOB_PAYLOAD,
        JOB_ORPHAN
    } t_job_kind;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_ORPHAN  = 2'd1;
    localparam logic [1:0] STATUS_ABANDON = 2'd2;

    localparam logic [1:0] CFG_FRAME_TAG          = 2'd0;
    localparam logic [1:0] CFG_DATA_OPCODE        = 2'd1;
    localparam logic [1:0] CFG_DATA_REPEAT_OPCODE = 2'd2;

    localparam logic [15:0] FRAME_TAG_RESET   = 16'hF0A1;
    localparam logic [7:0]  DATA_OPCODE_RESET = 8'd1;
    localparam logic [7:0]  DATA_REPEAT_RESET = 8'd2;

    localparam logic [7:0] MAX_PAYLOAD = 8'd242;
    localparam logic [7:0] END_BYTE    = 8'h00;

    // Result step numbers within one job.
    localparam logic [3:0] STEP_HDR_LAST  = 4'd11;
    localparam logic [3:0] STEP_HDR_SUM   = 4'd12;
    localparam logic [3:0] STEP_HDR_END   = 4'd13;
    localparam logic [3:0] STEP_PAY_SUM   = 4'd1;
    localparam logic [3:0] STEP_PAY_END   = 4'd2;
    localparam logic [3:0] STEP_FIRST     = 4'd0;

    typedef struct packed {
        t_job_kind   kind;
        logic [1:0]  status;
        logic        close;
        logic [7:0]  data;
        logic [7:0]  len;
        logic [15:0] tag;
        logic [15:0] pcount;
        logic [15:0] pindex;
        logic [31:0] ecc;
    } t_job;

endpackage

[rtl/core/radio_packet_framer_sum8_top.sv]
// Packet framer with an 8-bit additive checksum. A start beat (cmd 0) opens a frame
// and yields a 12-byte header; a framed payload beat (cmd 1) yields its byte; the
// beat that carries the last payload byte also yields the modulo-256 sum of every
// frame byte and a zero end byte. A start beat with a zero length yields all 14
// bytes. The result channel moves one byte per beat, one beat per cycle at most, and
// the input side takes one beat per cycle while the job queue has room, so payload
// beats flow at one per cycle while the receiver does not stall; a header takes 12
// (or 14) result beats of the output side, absorbed by a job queue of QUEUE_DEPTH
// entries. Each accepted beat goes through the job queue and the output register.

module radio_packet_framer_sum8_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // Input channel.
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_cmd,
    input  logic [7:0]  i_packet_command,
    input  logic        i_has_update_para,
    input  logic [15:0] i_package_count,
    input  logic [15:0] i_package_index,
    input  logic [31:0] i_ecc_word,
    input  logic [7:0]  i_payload_len,
    input  logic [7:0]  i_payload_byte,

    // Result channel.
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_last_of_run,
    output logic        o_frame_done,
    output logic [1:0]  o_status,

    // Configuration write channel: index 0 frame tag, 1 data opcode,
    // 2 data repeat opcode. Writes to other indexes are ignored.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import rpfs_pkg::*;

    t_job push_job;
    t_job head_job;
    logic push;
    logic pop;
    logic q_full;
    logic q_empty;

    // Registers are always writable; software must write them only while idle, and the block does not enforce it.
    assign o_cfg_ready = 1'b1;

    // The front end classifies each beat, tracks whether a packet is open and
    // how many payload bytes remain, and resolves the header fields.
    rpfs_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_cmd             (i_cmd),
        .i_packet_command  (i_packet_command),
        .i_has_update_para (i_has_update_para),
        .i_package_count   (i_package_count),
        .i_package_index   (i_package_index),
        .i_ecc_word        (i_ecc_word),
        .i_payload_len     (i_payload_len),
        .i_payload_byte    (i_payload_byte),
        .i_cfg_valid       (i_cfg_valid && o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_q_full          (q_full),
        .o_push            (push),
        .o_job             (push_job)
    );

    // The queue decouples the two sides so a long header run does not stall
    // the input until the queue fills.
    rpfs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // The back end serializes each job into result beats, keeps the running
    // checksum, and holds the result in an output register.
    rpfs_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job         (head_job),
        .i_q_empty     (q_empty),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run),
        .o_frame_done  (o_frame_done),
        .o_status      (o_status)
    );

endmodule

[rtl/core/rpfs_front.sv]
module rpfs_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_cmd,
    input  logic [7:0]        i_packet_command,
    input  logic              i_has_update_para,
    input  logic [15:0]       i_package_count,
    input  logic [15:0]       i_package_index,
    input  logic [31:0]       i_ecc_word,
    input  logic [7:0]        i_payload_len,
    input  logic [7:0]        i_payload_byte,
    input  logic              i_cfg_valid,
    input  logic [1:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data,
    input  logic              i_q_full,
    output logic              o_push,
    output rpfs_pkg::t_job    o_job
);
    import rpfs_pkg::*;

    logic [15:0] r_frame_tag;
    logic [7:0]  r_data_opcode;
    logic [7:0]  r_data_repeat_opcode;
    logic        r_open;
    logic [7:0]  r_remaining;
    logic        n_open;
    logic [7:0]  n_remaining;
    logic [7:0]  len_clamped;
    logic        accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_tag          <= FRAME_TAG_RESET;
            r_data_opcode        <= DATA_OPCODE_RESET;
            r_data_repeat_opcode <= DATA_REPEAT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FRAME_TAG:          r_frame_tag <= i_cfg_data;
                CFG_DATA_OPCODE:        r_data_opcode <= i_cfg_data[7:0];
                CFG_DATA_REPEAT_OPCODE: r_data_repeat_opcode <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign accept      = i_valid && !i_q_full;
    assign o_stall     = i_q_full;
    assign o_push      = accept;
    assign len_clamped = (i_payload_len > MAX_PAYLOAD) ? MAX_PAYLOAD : i_payload_len;

    // Classify the beat and work out the framing state it leaves behind.
    always_comb begin
        o_job       = '0;
        n_open      = r_open;
        n_remaining = r_remaining;
        if (!i_cmd) begin
            o_job.kind   = JOB_HEADER;
            o_job.status = r_open ? STATUS_ABANDON : STATUS_OK;
            o_job.close  = (len_clamped == 8'd0);
            o_job.data   = i_packet_command;
            o_job.len    = len_clamped;
            o_job.tag    = r_frame_tag;
            o_job.pcount = i_has_update_para ? i_package_count : 16'd0;
            o_job.pindex = i_has_update_para ? i_package_index : 16'd0;
            o_job.ecc    = ((i_packet_command == r_data_opcode) ||
                            (i_packet_command == r_data_repeat_opcode)) ? i_ecc_word : 32'd0;
            n_open       = (len_clamped != 8'd0);
            n_remaining  = len_clamped;
        end else if (r_open) begin
            o_job.kind   = JOB_PAYLOAD;
            o_job.status = STATUS_OK;
            o_job.close  = (r_remaining == 8'd1);
            o_job.data   = i_payload_byte;
            n_remaining  = r_remaining - 8'd1;
            n_open       = (r_remaining != 8'd1);
        end else begin
            o_job.kind   = JOB_ORPHAN;
            o_job.status = STATUS_ORPHAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open      <= 1'b0;
            r_remaining <= 8'd0;
        end else if (accept) begin
            r_open      <= n_open;
            r_remaining <= n_remaining;
        end
    end

endmodule

[rtl/core/rpfs_queue.sv]
module rpfs_queue #(
    parameter int DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  rpfs_pkg::t_job    i_job,
    input  logic              i_pop,
    output rpfs_pkg::t_job    o_job,
    output logic              o_full,
    output logic              o_empty
);
    import rpfs_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[rtl/core/rpfs_back.sv]
`include "radio_packet_framer_sum8_top_macros.svh"

module rpfs_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rpfs_pkg::t_job    i_job,
    input  logic              i_q_empty,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [7:0]        o_out_byte,
    output logic              o_last_of_run,
    output logic              o_frame_done,
    output logic [1:0]        o_status
);
    import rpfs_pkg::*;

    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_out_last;
    logic        r_out_done;
    logic [1:0]  r_out_status;
    logic [3:0]  r_step;
    logic [3:0]  n_step;
    logic [7:0]  r_sum;
    logic [7:0]  n_sum;
    logic [7:0]  cur_byte;
    logic        cur_done;
    logic        cur_last;
    logic        load;

    assign load = !i_q_empty && (!r_out_valid || !i_stall);

    // Pick the byte for the current step of the job at the queue head.
    always_comb begin
        cur_byte = END_BYTE;
        cur_done = 1'b0;
        cur_last = 1'b0;
        n_sum    = r_sum;
        case (i_job.kind)
            JOB_HEADER: begin
                case (r_step)
                    4'd0:    cur_byte = i_job.tag[7:0];
                    4'd1:    cur_byte = i_job.tag[15:8];
                    4'd2:    cur_byte = i_job.data;
                    4'd3:    cur_byte = i_job.pcount[7:0];
                    4'd4:    cur_byte = i_job.pcount[15:8];
                    4'd5:    cur_byte = i_job.pindex[7:0];
                    4'd6:    cur_byte = i_job.pindex[15:8];
                    4'd7:    cur_byte = i_job.len;
                    4'd8:    cur_byte = i_job.ecc[7:0];
                    4'd9:    cur_byte = i_job.ecc[15:8];
                    4'd10:   cur_byte = i_job.ecc[23:16];
                    4'd11:   cur_byte = i_job.ecc[31:24];
                    4'd12:   cur_byte = r_sum;
                    default: cur_byte = END_BYTE;
                endcase
                if (r_step == STEP_FIRST) begin
                    n_sum = cur_byte;
                end else if (r_step <= STEP_HDR_LAST) begin
                    n_sum = r_sum + cur_byte;
                end
                cur_done = (r_step == STEP_HDR_END);
                cur_last = i_job.close ? (r_step == STEP_HDR_END) : (r_step == STEP_HDR_LAST);
            end
            JOB_PAYLOAD: begin
                case (r_step)
                    STEP_FIRST: begin
                        cur_byte = i_job.data;
                        n_sum    = r_sum + i_job.data;
                    end
                    STEP_PAY_SUM: cur_byte = r_sum;
                    default:      cur_byte = END_BYTE;
                endcase
                cur_done = (r_step == STEP_PAY_END);
                cur_last = i_job.close ? (r_step == STEP_PAY_END) : (r_step == STEP_FIRST);
            end
            default: begin
                cur_byte = END_BYTE;
                cur_last = 1'b1;
            end
        endcase
        n_step = cur_last ? STEP_FIRST : r_step + 4'd1;
    end

    assign o_pop = load && cur_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_step      <= STEP_FIRST;
            r_sum       <= 8'd0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                r_step      <= n_step;
                r_sum       <= n_sum;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_byte   <= cur_byte;
            r_out_last   <= cur_last;
            r_out_done   <= cur_done;
            r_out_status <= i_job.status;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_last_of_run = r_out_last;
    assign o_frame_done  = r_out_done;
    assign o_status      = r_out_status;

    `RPFS_ASSERT_IMPLIES(a_done_is_last_zero, i_clk, i_rst_n, r_out_valid && r_out_done, r_out_last && (r_out_byte == END_BYTE))
    `RPFS_ASSERT_IMPLIES(a_orphan_single, i_clk, i_rst_n, r_out_valid && (r_out_status == STATUS_ORPHAN), r_out_last && !r_out_done)
    `RPFS_ASSERT_IMPLIES(a_job_held_in_queue, i_clk, i_rst_n, r_step != STEP_FIRST, !i_q_empty)
    `RPFS_ASSERT_ALWAYS(a_step_in_range, i_clk, i_rst_n, r_step <= STEP_HDR_END)

endmodule

[dv/tb_radio_packet_framer_sum8_top.sv]
module tb_radio_packet_framer_sum8_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rpfs_pkg::*;

    // Values of the cmd field. A start beat opens a frame; a payload beat
    // carries one byte of the open frame.
    localparam logic CMD_START   = 1'b0;
    localparam logic CMD_PAYLOAD = 1'b1;

    // The configuration port has a fourth index that the block must ignore.
    localparam logic [1:0] CFG_UNUSED_INDEX = 2'd3;

    localparam int HEADER_BYTES = 12;
    localparam int MAX_RUN      = 14;
    localparam int DRAIN_CYCLES = 16;
    localparam int LIMIT_CYCLES = 500000;

    // One input beat, field by field.
    typedef struct {
        logic        cmd;
        logic [7:0]  command;
        logic        has_update;
        logic [15:0] pkg_count;
        logic [15:0] pkg_index;
        logic [31:0] ecc;
        logic [7:0]  len;
        logic [7:0]  data;
    } t_framer_beat;

    // One output beat: a byte of the frame and its flags.
    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       done;
        logic [1:0] status;
    } t_frame_byte;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic        i_cmd;
    logic [7:0]  i_packet_command;
    logic        i_has_update_para;
    logic [15:0] i_package_count;
    logic [15:0] i_package_index;
    logic [31:0] i_ecc_word;
    logic [7:0]  i_payload_len;
    logic [7:0]  i_payload_byte;
    logic        o_valid;
    logic        i_stall;
    logic [7:0]  o_out_byte;
    logic        o_last_of_run;
    logic        o_frame_done;
    logic [1:0]  o_status;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    // Our own copy of the configuration registers and of the framing state.
    logic [15:0] tag_reg;
    logic [7:0]  data_op_reg;
    logic [7:0]  repeat_op_reg;
    logic        frame_open;
    logic [7:0]  bytes_left;
    logic [7:0]  frame_sum;

    // Bytes that one input beat produces, collected before they are queued.
    t_frame_byte run_bytes [MAX_RUN];
    int          run_len;

    // Frame bytes still owed by the block, oldest first.
    t_frame_byte pending_bytes [$];

    int mismatch_count;
    int checked_count;
    int cycle_count;
    int send_idle_pct;
    int recv_stall_pct;

    radio_packet_framer_sum8_top DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_cmd             (i_cmd),
        .i_packet_command  (i_packet_command),
        .i_has_update_para (i_has_update_para),
        .i_package_count   (i_package_count),
        .i_package_index   (i_package_index),
        .i_ecc_word        (i_ecc_word),
        .i_payload_len     (i_payload_len),
        .i_payload_byte    (i_payload_byte),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_out_byte        (o_out_byte),
        .o_last_of_run     (o_last_of_run),
        .o_frame_done      (o_frame_done),
        .o_status          (o_status),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    // 2 ns clock. Inputs move on the falling edge, outputs are sampled on
    // the rising edge, so nothing depends on event order within a step.
    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // The receiver stalls at random, one decision per cycle.
    always @(negedge i_clk) begin
        i_stall = ($urandom_range(99) < recv_stall_pct);
    end

    // Prints one line per mismatch and counts every one.
    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("mismatch on result beat %0d: %s got %h expected %h",
                 checked_count, what, got, want);
        mismatch_count++;
    endtask

    // Appends one byte to the current run and folds it into the checksum.
    task automatic add_byte(input logic [7:0] data, input logic done,
                            input logic [1:0] status);
        run_bytes[run_len] = '{data: data, last: 1'b0, done: done, status: status};
        run_len++;
        frame_sum = frame_sum + data;
    endtask

    // Checksum byte and end byte, then the frame is closed.
    task automatic close_frame(input logic [1:0] status);
        add_byte(frame_sum, 1'b0, status);
        add_byte(END_BYTE, 1'b1, status);
        frame_open = 1'b0;
        bytes_left = '0;
        frame_sum  = '0;
    endtask

    // Works out every frame byte that one accepted beat must produce and
    // queues them in order, with the last one of the run marked.
    task automatic build_frame_bytes(input t_framer_beat b);
        logic [7:0]  hdr [HEADER_BYTES];
        logic [15:0] count_f;
        logic [15:0] index_f;
        logic [31:0] ecc_f;
        logic [7:0]  len_f;
        logic [1:0]  status;
        run_len = 0;
        if (b.cmd == CMD_START) begin
            // A start while a frame is open drops that frame silently, and
            // every byte of the new header says so.
            status  = frame_open ? STATUS_ABANDON : STATUS_OK;
            count_f = b.has_update ? b.pkg_count : 16'h0000;
            index_f = b.has_update ? b.pkg_index : 16'h0000;
            ecc_f   = (b.command == data_op_reg || b.command == repeat_op_reg) ?
                      b.ecc : 32'h0000_0000;
            len_f   = (b.len > MAX_PAYLOAD) ? MAX_PAYLOAD : b.len;
            hdr[0]  = tag_reg[7:0];
            hdr[1]  = tag_reg[15:8];
            hdr[2]  = b.command;
            hdr[3]  = count_f[7:0];
            hdr[4]  = count_f[15:8];
            hdr[5]  = index_f[7:0];
            hdr[6]  = index_f[15:8];
            hdr[7]  = len_f;
            hdr[8]  = ecc_f[7:0];
            hdr[9]  = ecc_f[15:8];
            hdr[10] = ecc_f[23:16];
            hdr[11] = ecc_f[31:24];
            frame_sum = '0;
            for (int i = 0; i < HEADER_BYTES; i++)
                add_byte(hdr[i], 1'b0, status);
            // An empty frame closes right behind its header.
            if (len_f == 8'd0) begin
                close_frame(status);
            end else begin
                frame_open = 1'b1;
                bytes_left = len_f;
            end
        end else if (!frame_open) begin
            // A stray payload byte yields a flagged zero and leaves the
            // checksum alone.
            add_byte(8'h00, 1'b0, STATUS_ORPHAN);
        end else begin
            add_byte(b.data, 1'b0, STATUS_OK);
            bytes_left = bytes_left - 8'd1;
            if (bytes_left == 8'd0)
                close_frame(STATUS_OK);
        end
        run_bytes[run_len - 1].last = 1'b1;
        for (int i = 0; i < run_len; i++)
            pending_bytes.push_back(run_bytes[i]);
    endtask

    // Every result beat is matched against the oldest byte still owed.
    always @(posedge i_clk) begin : result_check
        t_frame_byte want;
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (pending_bytes.size() == 0) begin
                flag_mismatch("beat with nothing owed, out_byte", 32'(o_out_byte), 32'd0);
            end else begin
                want = pending_bytes.pop_front();
                if (o_out_byte !== want.data)
                    flag_mismatch("out_byte", 32'(o_out_byte), 32'(want.data));
                if (o_last_of_run !== want.last)
                    flag_mismatch("last_of_run", 32'(o_last_of_run), 32'(want.last));
                if (o_frame_done !== want.done)
                    flag_mismatch("frame_done", 32'(o_frame_done), 32'(want.done));
                if (o_status !== want.status)
                    flag_mismatch("status", 32'(o_status), 32'(want.status));
            end
            checked_count++;
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // A beat with every field random; callers override what matters.
    function automatic t_framer_beat random_beat(input logic cmd);
        t_framer_beat b;
        b.cmd        = cmd;
        b.command    = 8'($urandom_range(255));
        b.has_update = 1'($urandom_range(1));
        b.pkg_count  = 16'($urandom_range(65535));
        b.pkg_index  = 16'($urandom_range(65535));
        b.ecc        = $urandom();
        b.len        = 8'($urandom_range(255));
        b.data       = 8'($urandom_range(255));
        return b;
    endfunction

    // Sends one beat, with random idle cycles in front of it. Called on a
    // falling edge; returns on the falling edge after the beat is taken.
    // Valid stays high afterward, so back-to-back beats follow with no gap.
    task automatic send_beat(input t_framer_beat b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_cmd             = b.cmd;
        i_packet_command  = b.command;
        i_has_update_para = b.has_update;
        i_package_count   = b.pkg_count;
        i_package_index   = b.pkg_index;
        i_ecc_word        = b.ecc;
        i_payload_len     = b.len;
        i_payload_byte    = b.data;
        i_valid           = 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        build_frame_bytes(b);
        @(negedge i_clk);
    endtask

    task automatic send_start(input logic [7:0] len, input logic [7:0] command);
        t_framer_beat b;
        b         = random_beat(CMD_START);
        b.len     = len;
        b.command = command;
        send_beat(b);
    endtask

    task automatic send_payload(input logic [7:0] data);
        t_framer_beat b;
        b      = random_beat(CMD_PAYLOAD);
        b.data = data;
        send_beat(b);
    endtask

    // Lowers valid and waits until every owed byte has come out, plus a
    // margin for the pipeline, so that registers can be written safely.
    task automatic wait_until_drained();
        i_valid = 1'b0;
        while (pending_bytes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // One register write; the opcode registers keep only the low byte.
    task automatic write_register(input logic [1:0] idx, input logic [15:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_FRAME_TAG:          tag_reg = data;
            CFG_DATA_OPCODE:        data_op_reg = data[7:0];
            CFG_DATA_REPEAT_OPCODE: repeat_op_reg = data[7:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Random settings; the two data opcodes coincide now and then.
    task automatic set_random_config();
        logic [15:0] op_word;
        write_register(CFG_FRAME_TAG, 16'($urandom_range(65535)));
        op_word = 16'($urandom_range(65535));
        write_register(CFG_DATA_OPCODE, op_word);
        if ($urandom_range(3) == 0)
            write_register(CFG_DATA_REPEAT_OPCODE, {~op_word[15:8], op_word[7:0]});
        else
            write_register(CFG_DATA_REPEAT_OPCODE, 16'($urandom_range(65535)));
        write_register(CFG_UNUSED_INDEX, 16'($urandom_range(65535)));
    endtask

    // A payload byte straight after reset, with no frame open.
    task automatic test_orphan_after_reset();
        send_payload(8'hFF);
    endtask

    // Header fields at their extremes under the reset settings, including
    // the length clamp and starts that abandon an open frame.
    task automatic test_header_extremes();
        t_framer_beat b;
        // Plain command: counts and ECC must read as zeros.
        b            = random_beat(CMD_START);
        b.command    = 8'h00;
        b.has_update = 1'b0;
        b.pkg_count  = 16'hFFFF;
        b.pkg_index  = 16'hFFFF;
        b.ecc        = 32'hFFFF_FFFF;
        b.len        = 8'd0;
        send_beat(b);
        // Data command with all fields carried.
        b            = random_beat(CMD_START);
        b.command    = DATA_OPCODE_RESET;
        b.has_update = 1'b1;
        b.pkg_count  = 16'hFFFF;
        b.pkg_index  = 16'h0000;
        b.ecc        = 32'hFFFF_FFFF;
        b.len        = 8'd0;
        send_beat(b);
        // Repeat command, largest length: header shows the clamped value.
        b            = random_beat(CMD_START);
        b.command    = DATA_REPEAT_RESET;
        b.has_update = 1'b1;
        b.pkg_count  = 16'h0000;
        b.pkg_index  = 16'hFFFF;
        b.ecc        = 32'h0000_0000;
        b.len        = 8'd255;
        send_beat(b);
        // This start drops the frame above; so does the empty one after it.
        send_start(8'd243, 8'hFF);
        send_start(8'd0, DATA_OPCODE_RESET);
    endtask

    // Pass-through bytes, checksum closing, abandon mid-payload, and a
    // stray byte once the frame has closed.
    task automatic test_payload_and_abandon();
        send_start(8'd2, 8'h5A);
        send_payload(8'hFF);
        send_payload(8'h00);
        send_start(8'd3, DATA_REPEAT_RESET);
        send_payload(8'($urandom_range(255)));
        send_start(8'd1, 8'h80);
        send_payload(8'hA5);
        send_payload(8'($urandom_range(255)));
    endtask

    // Register extremes, upper data bits on the opcode registers, and a
    // write to the unused index that must change nothing.
    task automatic test_config_extremes();
        wait_until_drained();
        write_register(CFG_FRAME_TAG, 16'h0000);
        write_register(CFG_DATA_OPCODE, 16'hFF00);
        write_register(CFG_DATA_REPEAT_OPCODE, 16'h00FF);
        write_register(CFG_UNUSED_INDEX, 16'hFFFF);
        send_start(8'd0, 8'h00);
        send_start(8'd0, 8'hFF);
        send_start(8'd0, 8'h7F);
        wait_until_drained();
        write_register(CFG_FRAME_TAG, 16'hFFFF);
        write_register(CFG_DATA_OPCODE, 16'h12FF);
        write_register(CFG_DATA_REPEAT_OPCODE, 16'hFF00);
        send_start(8'd1, 8'h00);
        send_payload(8'($urandom_range(255)));
        send_start(8'd0, 8'hFF);
    endtask

    // Random traffic, mostly whole frames with random content. Some frames
    // are cut short (the next start abandons them), and some beats are stray
    // payload bytes. Lengths are mostly short, a few are long or clamped.
    // A frame that would overrun the phase is cut short so the phase stays in budget.
    task automatic run_random_traffic(input int n_items, input bit long_first);
        int          sent;
        int          pick;
        int          len_pick;
        int          eff_len;
        int          n_pay;
        logic [7:0]  len;
        logic [7:0]  command;
        sent = 0;
        while (sent < n_items) begin
            pick     = $urandom_range(99);
            len_pick = $urandom_range(99);
            if (long_first && sent == 0)
                len = 8'd255;
            else if (len_pick < 6)
                len = 8'd0;
            else if (len_pick < 8)
                len = 8'($urandom_range(255, 243));
            else if (len_pick < 10)
                len = 8'($urandom_range(242, 128));
            else
                len = 8'($urandom_range(12, 1));
            pick = (long_first && sent == 0) ? 99 : pick;
            if (pick < 8) begin
                send_payload(8'($urandom_range(255)));
                sent++;
            end else begin
                if ($urandom_range(99) < 35)
                    command = data_op_reg;
                else if ($urandom_range(99) < 40)
                    command = repeat_op_reg;
                else
                    command = 8'($urandom_range(255));
                eff_len = int'((len > MAX_PAYLOAD) ? MAX_PAYLOAD : len);
                n_pay   = (pick < 16 && eff_len > 0) ? int'($urandom_range(eff_len - 1)) :
                          eff_len;
                if (n_pay > n_items - sent - 1)
                    n_pay = n_items - sent - 1;
                send_start(len, command);
                sent++;
                repeat (n_pay) begin
                    send_payload(8'($urandom_range(255)));
                    sent++;
                end
            end
        end
    endtask

    // One random phase: fresh settings while idle, then traffic under the
    // given sender idle and receiver stall rates.
    task automatic run_phase(input int idle_pct, input int stall_pct,
                             input int n_items, input bit long_first);
        wait_until_drained();
        set_random_config();
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        run_random_traffic(n_items, long_first);
    endtask

    // Random traffic through every idling mix, including none at all.
    task automatic test_random_traffic();
        run_phase(0, 0, 250, 1'b1);
        run_phase(64, 0, 85, 1'b0);
        run_phase(0, 64, 85, 1'b0);
        run_phase(33, 33, 85, 1'b0);
    endtask

    initial begin
        i_rst_n           = 1'b0;
        i_valid           = 1'b0;
        i_cmd             = CMD_START;
        i_packet_command  = '0;
        i_has_update_para = 1'b0;
        i_package_count   = '0;
        i_package_index   = '0;
        i_ecc_word        = '0;
        i_payload_len     = '0;
        i_payload_byte    = '0;
        i_cfg_valid       = 1'b0;
        i_cfg_index       = CFG_FRAME_TAG;
        i_cfg_data        = '0;
        tag_reg           = FRAME_TAG_RESET;
        data_op_reg       = DATA_OPCODE_RESET;
        repeat_op_reg     = DATA_REPEAT_RESET;
        frame_open        = 1'b0;
        bytes_left        = '0;
        frame_sum         = '0;
        mismatch_count    = 0;
        checked_count     = 0;
        send_idle_pct     = 0;
        recv_stall_pct    = 0;

        // Synchronous reset, released on a falling edge.
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_orphan_after_reset();
        test_header_extremes();
        test_payload_and_abandon();
        test_config_extremes();
        test_random_traffic();

        // All stimulus is in; let the last bytes drain and keep checking through the
        // drain margin for anything the block should not send.
        wait_until_drained();
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
